@@ src/sst_pkg.sv @@
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants of the strided service table scorer
// Holds the service identifier list, result status codes and cell types.
// ----------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

    localparam int SERVICE_COUNT = 33;
    localparam int SCORE_W       = 6;
    localparam int STRIDE_W      = 6;
    localparam int SLOT_W        = 6;

    localparam logic [STRIDE_W-1:0] STRIDE_FIRST = 6'd6;
    localparam logic [STRIDE_W-1:0] STRIDE_LAST  = 6'd32;
    localparam logic [STRIDE_W-1:0] STRIDE_STEP  = 6'd2;

    localparam logic [7:0] SERVICE_IDS [SERVICE_COUNT] = '{
        8'h10, 8'h11, 8'h27, 8'h28, 8'h3E, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h22,
        8'h23, 8'h24, 8'h2A, 8'h2C, 8'h2D, 8'h2E, 8'h3D, 8'h14, 8'h19, 8'h2F, 8'h31,
        8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h18, 8'h3B, 8'h20, 8'h21, 8'h1A
    };

    typedef enum logic [1:0] {
        ST_CAND  = 2'd0,
        ST_NONE  = 2'd1,
        ST_SHORT = 2'd2
    } status_t;

    localparam logic REG_BASE = 1'b0;

    typedef struct packed {
        logic [SCORE_W-1:0]  score;
        logic [STRIDE_W-1:0] stride;
    } rank_t;

    typedef struct packed {
        logic clr;
        logic ins;
        logic pop;
    } cell_ctl_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] idx;
    } slot_t;

    function automatic slot_t service_slot(input logic [7:0] b);
        slot_t r;
        r = '0;
        for (int j = SERVICE_COUNT - 1; j >= 0; j--) begin
            if (SERVICE_IDS[j] == b) begin
                r.hit = 1'b1;
                r.idx = SLOT_W'(j);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/sst_byte_if.sv @@
// ----------------------------------------------------------------------------
// sst_byte_if: image byte channel
// Valid/ready channel carrying one image byte and its end marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface sst_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

`default_nettype wire

@@ src/sst_res_if.sv @@
// ----------------------------------------------------------------------------
// sst_res_if: result channel
// Valid/ready channel carrying one ranked candidate or a status result.
// ----------------------------------------------------------------------------
`default_nettype none

interface sst_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] found_address;
    logic [5:0]  score;
    logic [5:0]  stride;
    logic [1:0]  status;
    logic        last_res;

    modport source (output valid, output found_address, output score, output stride,
                    output status, output last_res, input ready);
    modport sink   (input valid, input found_address, input score, input stride,
                    input status, input last_res, output ready);
endinterface

`default_nettype wire

@@ src/strided_service_table_scorer.sv @@
// ----------------------------------------------------------------------------
// strided_service_table_scorer: strided service identifier table search
// Stores an image, scores every start position and reports the best ones.
// ----------------------------------------------------------------------------
// Image bytes arrive on the bytes channel, one transfer per cycle while the
// block is loading; the transfer with last set starts the scan. Bytes past
// MAX_BYTES are dropped. The base address is written over the APB port.
// The scan reads the byte store through its one read port, then checks
// the byte for membership, and repeats this over fourteen strides for
// each start position. A position's best nonzero score enters the
// ranked list in the same cycle as its last check.
// Results then leave on the results channel, at most one transfer per
// cycle, highest score first, the final one marked by last_res. A short
// image gives a single status result. While the receiver stalls the result
// register holds and the report waits; once the final result sits in
// the register a new image can already be loaded. Reset empties the list,
// the byte count and the base address; the byte store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module strided_service_table_scorer #(
    parameter int MAX_BYTES    = 65536,
    parameter int WINDOW_BYTES = 512,
    parameter int TOP_COUNT    = 20
) (
    input  wire          clk,
    input  wire          rst_n,
    sst_byte_if.sink     bytes,
    sst_res_if.source    results,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [3:0]   paddr,
    input  wire  [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    localparam int AW  = $clog2(MAX_BYTES);
    localparam int CWA = $clog2(MAX_BYTES) + 1;
    localparam int CWB = $clog2(2 * WINDOW_BYTES) + 1;
    localparam int CW  = (CWA > CWB) ? CWA : CWB;
    localparam int KW  = $clog2(WINDOW_BYTES + 32) + 1;
    localparam int SW  = CW + KW;
    localparam logic [CW-1:0] MAX_C   = CW'(MAX_BYTES);
    localparam logic [CW-1:0] TWO_W_C = CW'(2 * WINDOW_BYTES);
    localparam logic [KW-1:0] WIN_C   = KW'(WINDOW_BYTES);

    typedef enum logic [2:0] {
        S_LOAD,
        S_RD,
        S_CHK,
        S_OUT,
        S_ERR
    } state_t;

    state_t                            state_reg, state_next;
    logic [CW-1:0]                     count_reg, count_next;
    logic [CW-1:0]                     limit_reg, limit_next;
    logic [CW-1:0]                     pos_reg, pos_next;
    logic [KW-1:0]                     k_reg, k_next;
    logic [sst_pkg::STRIDE_W-1:0]      stride_reg, stride_next;
    logic [sst_pkg::SCORE_W-1:0]       hits_reg, hits_next;
    logic [sst_pkg::SERVICE_COUNT-1:0] used_reg, used_next;
    sst_pkg::rank_t                    best_reg, best_next;
    logic [63:0]                       base_reg, base_next;
    logic                              rv_reg, rv_next;
    logic [63:0]                       addr_reg, addr_next;
    sst_pkg::rank_t                    rr_reg, rr_next;
    sst_pkg::status_t                  status_reg, status_next;
    logic                              fin_reg, fin_next;

    logic [7:0]          mem [MAX_BYTES];
    logic [7:0]          rd_data_reg;
    logic [AW-1:0]       rd_addr;
    logic                mem_we;

    sst_pkg::cell_ctl_t  ctl;
    sst_pkg::rank_t      ins_rank;
    sst_pkg::rank_t      head_rank;
    logic [AW-1:0]       head_pos;
    logic                second_empty;

    sst_pkg::slot_t              slot;
    logic                        match;
    logic [sst_pkg::SCORE_W-1:0] hits_fin;
    logic [KW-1:0]               k_step;
    logic                        out_free;
    logic [CW-1:0]               size;
    logic [SW-1:0]               sum;

    assign bytes.ready = (state_reg == S_LOAD);
    assign pready      = 1'b1;
    assign prdata      = (paddr == 4'd0) ? base_reg : 64'd0;

    assign sum      = SW'(pos_reg) + SW'(k_reg);
    assign rd_addr  = sum[AW-1:0];
    assign slot     = sst_pkg::service_slot(rd_data_reg);
    assign match    = slot.hit && !used_reg[slot.idx];
    assign hits_fin = hits_reg + sst_pkg::SCORE_W'(match);
    assign k_step   = k_reg + KW'(stride_reg);
    assign out_free = !rv_reg || results.ready;
    assign mem_we   = (state_reg == S_LOAD) && bytes.valid && (count_reg < MAX_C);
    assign size     = mem_we ? count_reg + CW'(1) : count_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[AW-1:0]] <= bytes.data_byte;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        limit_next  = limit_reg;
        pos_next    = pos_reg;
        k_next      = k_reg;
        stride_next = stride_reg;
        hits_next   = hits_reg;
        used_next   = used_reg;
        best_next   = best_reg;
        base_next   = base_reg;
        rv_next     = rv_reg && !results.ready;
        addr_next   = addr_reg;
        rr_next     = rr_reg;
        status_next = status_reg;
        fin_next    = fin_reg;
        ctl         = '0;
        ins_rank    = '0;

        if (psel && penable && pwrite && (paddr == 4'd0))
        begin
            base_next = pwdata;
        end

        case (state_reg)
            S_LOAD:
            begin
                if (bytes.valid)
                begin
                    count_next = size;
                    if (bytes.last)
                    begin
                        count_next = '0;
                        if (size < TWO_W_C)
                        begin
                            state_next = S_ERR;
                        end
                        else
                        begin
                            ctl.clr     = 1'b1;
                            limit_next  = size - TWO_W_C;
                            pos_next    = CW'(1);
                            k_next      = '0;
                            stride_next = sst_pkg::STRIDE_FIRST;
                            hits_next   = '0;
                            used_next   = '0;
                            best_next   = '0;
                            state_next  = (size - TWO_W_C <= CW'(1)) ? S_OUT : S_RD;
                        end
                    end
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (match && (k_step < WIN_C))
                begin
                    hits_next = hits_fin;
                    used_next = used_reg | (sst_pkg::SERVICE_COUNT'(1) << slot.idx);
                    k_next    = k_step;
                    state_next = S_RD;
                end
                else
                begin
                    if (hits_fin > best_reg.score)
                    begin
                        best_next.score  = hits_fin;
                        best_next.stride = stride_reg;
                    end
                    k_next     = '0;
                    hits_next  = '0;
                    used_next  = '0;
                    state_next = S_RD;
                    if (stride_reg == sst_pkg::STRIDE_LAST)
                    begin
                        ins_rank    = best_next;
                        ctl.ins     = (best_next.score != '0);
                        best_next   = '0;
                        stride_next = sst_pkg::STRIDE_FIRST;
                        pos_next    = pos_reg + CW'(1);
                        if (pos_reg + CW'(1) == limit_reg)
                        begin
                            state_next = S_OUT;
                        end
                    end
                    else
                    begin
                        stride_next = stride_reg + sst_pkg::STRIDE_STEP;
                    end
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    rv_next = 1'b1;
                    if (head_rank.score == '0)
                    begin
                        addr_next   = '0;
                        rr_next     = '0;
                        status_next = sst_pkg::ST_NONE;
                        fin_next    = 1'b1;
                        state_next  = S_LOAD;
                    end
                    else
                    begin
                        ctl.pop     = 1'b1;
                        addr_next   = base_reg + 64'(head_pos);
                        rr_next     = head_rank;
                        status_next = sst_pkg::ST_CAND;
                        fin_next    = second_empty;
                        if (second_empty)
                        begin
                            state_next = S_LOAD;
                        end
                    end
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    rv_next     = 1'b1;
                    addr_next   = '0;
                    rr_next     = '0;
                    status_next = sst_pkg::ST_SHORT;
                    fin_next    = 1'b1;
                    state_next  = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            count_reg  <= '0;
            limit_reg  <= '0;
            pos_reg    <= '0;
            k_reg      <= '0;
            stride_reg <= sst_pkg::STRIDE_FIRST;
            hits_reg   <= '0;
            used_reg   <= '0;
            best_reg   <= '0;
            base_reg   <= '0;
            rv_reg     <= 1'b0;
            addr_reg   <= '0;
            rr_reg     <= '0;
            status_reg <= sst_pkg::ST_CAND;
            fin_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            limit_reg  <= limit_next;
            pos_reg    <= pos_next;
            k_reg      <= k_next;
            stride_reg <= stride_next;
            hits_reg   <= hits_next;
            used_reg   <= used_next;
            best_reg   <= best_next;
            base_reg   <= base_next;
            rv_reg     <= rv_next;
            addr_reg   <= addr_next;
            rr_reg     <= rr_next;
            status_reg <= status_next;
            fin_reg    <= fin_next;
        end
    end

    sst_chain #(.TOP_COUNT(TOP_COUNT), .PW(AW)) u_chain (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .new_rank     (ins_rank),
        .new_pos      (pos_reg[AW-1:0]),
        .head_rank    (head_rank),
        .head_pos     (head_pos),
        .second_empty (second_empty)
    );

    assign results.valid         = rv_reg;
    assign results.found_address = addr_reg;
    assign results.score         = rr_reg.score;
    assign results.stride        = rr_reg.stride;
    assign results.status        = status_reg;
    assign results.last_res      = fin_reg;

endmodule

`default_nettype wire

@@ src/sst_cell.sv @@
// ----------------------------------------------------------------------------
// sst_cell: one entry of the ranked candidate list
// Clears, or takes the new candidate, its upper neighbour's entry or its lower one.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_cell #(
    parameter int PW = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  sst_pkg::cell_ctl_t  ctl,
    input  sst_pkg::rank_t      new_rank,
    input  wire [PW-1:0]        new_pos,
    input  sst_pkg::rank_t      prev_rank,
    input  wire [PW-1:0]        prev_pos,
    input  wire                 prev_less,
    input  sst_pkg::rank_t      next_rank,
    input  wire [PW-1:0]        next_pos,
    output sst_pkg::rank_t      rank,
    output logic [PW-1:0]       pos,
    output logic                less
);

    sst_pkg::rank_t rank_reg;
    sst_pkg::rank_t rank_next;
    logic [PW-1:0]  pos_reg;
    logic [PW-1:0]  pos_next;

    assign less = rank_reg.score < new_rank.score;

    always_comb
    begin
        rank_next = rank_reg;
        pos_next  = pos_reg;
        if (ctl.clr)
        begin
            rank_next = '0;
            pos_next  = '0;
        end
        else if (ctl.ins && less)
        begin
            rank_next = prev_less ? prev_rank : new_rank;
            pos_next  = prev_less ? prev_pos : new_pos;
        end
        else if (ctl.pop)
        begin
            rank_next = next_rank;
            pos_next  = next_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg <= '0;
            pos_reg  <= '0;
        end
        else
        begin
            rank_reg <= rank_next;
            pos_reg  <= pos_next;
        end
    end

    assign rank = rank_reg;
    assign pos  = pos_reg;

endmodule

`default_nettype wire

@@ src/sst_chain.sv @@
// ----------------------------------------------------------------------------
// sst_chain: ranked candidate list as a row of cells
// Inserts by shifting down and pops the head by shifting up.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_chain #(
    parameter int TOP_COUNT = 20,
    parameter int PW        = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  sst_pkg::cell_ctl_t  ctl,
    input  sst_pkg::rank_t      new_rank,
    input  wire [PW-1:0]        new_pos,
    output sst_pkg::rank_t      head_rank,
    output logic [PW-1:0]       head_pos,
    output logic                second_empty
);

    sst_pkg::rank_t rank_w [TOP_COUNT+1];
    logic [PW-1:0]  pos_w  [TOP_COUNT+1];
    logic           less_w [TOP_COUNT];

    assign rank_w[TOP_COUNT] = '0;
    assign pos_w[TOP_COUNT]  = '0;

    for (genvar i = 0; i < TOP_COUNT; i++)
    begin : g_cell
        sst_pkg::rank_t p_rank;
        logic [PW-1:0]  p_pos;
        logic           p_less;
        if (i == 0)
        begin : g_head
            assign p_rank = new_rank;
            assign p_pos  = new_pos;
            assign p_less = 1'b0;
        end
        else
        begin : g_body
            assign p_rank = rank_w[i-1];
            assign p_pos  = pos_w[i-1];
            assign p_less = less_w[i-1];
        end
        sst_cell #(.PW(PW)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .new_rank  (new_rank),
            .new_pos   (new_pos),
            .prev_rank (p_rank),
            .prev_pos  (p_pos),
            .prev_less (p_less),
            .next_rank (rank_w[i+1]),
            .next_pos  (pos_w[i+1]),
            .rank      (rank_w[i]),
            .pos       (pos_w[i]),
            .less      (less_w[i])
        );
    end

    assign head_rank    = rank_w[0];
    assign head_pos     = pos_w[0];
    assign second_empty = (rank_w[1].score == '0);

endmodule

`default_nettype wire

@@ src/sst_checker.sv @@
// ----------------------------------------------------------------------------
// sst_checker: port-level checks of the scorer
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        res_valid,
    input wire        res_ready,
    input wire [63:0] res_addr,
    input wire [5:0]  res_score,
    input wire [5:0]  res_stride,
    input wire [1:0]  res_status,
    input wire        res_last
);

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result valid dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_addr) && $stable(res_score)
            && $stable(res_status) && $stable(res_last))
        else $error("result payload changed while stalled");

    a_status_final: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status != 2'd0) |-> res_last && (res_score == 6'd0)
            && (res_stride == 6'd0) && (res_addr == 64'd0))
        else $error("status result is not a bare final transfer");

    a_cand_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status == 2'd0) |-> (res_score != 6'd0) && (res_stride >= 6'd6)
            && (res_stride <= 6'd32) && !res_stride[0] && (res_score <= 6'd33))
        else $error("candidate with impossible score or stride");

endmodule

bind strided_service_table_scorer sst_checker u_sst_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (results.valid),
    .res_ready  (results.ready),
    .res_addr   (results.found_address),
    .res_score  (results.score),
    .res_stride (results.stride),
    .res_status (results.status),
    .res_last   (results.last_res)
);

`default_nettype wire
